@@ hdl/eia_pkg.sv @@
`timescale 1ns / 1ps
package eia_pkg;
   typedef enum logic [5:0] {
      OP_ADD = 6'd0, OP_SUB = 6'd1, OP_MUL = 6'd2, OP_DIV = 6'd3, OP_QUOT = 6'd4,
      OP_REM = 6'd5, OP_MOD = 6'd6, OP_GCD = 6'd7, OP_LCM = 6'd8, OP_MIN = 6'd9,
      OP_MAX = 6'd10, OP_ABS = 6'd11, OP_NEG = 6'd12, OP_AND = 6'd13, OP_OR = 6'd14,
      OP_XOR = 6'd15, OP_NOT = 6'd16, OP_SLL = 6'd17, OP_SRL = 6'd18, OP_SLA = 6'd19,
      OP_SRA = 6'd20, OP_LT = 6'd21, OP_LE = 6'd22, OP_EQ = 6'd23, OP_GE = 6'd24,
      OP_GT = 6'd25, OP_ODD = 6'd26, OP_EVEN = 6'd27, OP_ZERO = 6'd28,
      OP_POS = 6'd29, OP_NEGP = 6'd30, OP_INC = 6'd31, OP_DEC = 6'd32
   } op_type;

   typedef enum logic [1:0] {
      ERR_OK = 2'd0, ERR_DIV_ZERO = 2'd1, ERR_INEXACT = 2'd2
   } err_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_GCD, ST_LCM_DIV, ST_MUL, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      CMD_NONE, CMD_LOAD, CMD_DIV_STEP, CMD_GCD_START, CMD_GCD_NEXT, CMD_LCM_LOAD,
      CMD_MUL_STEP, CMD_FINISH
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
   } ctl_type;

   typedef struct packed {
      logic div_done;
      logic gcd_zero;
      logic mul_done;
      logic is_div;
      logic is_gcd;
      logic is_lcm;
      logic req_div;
      logic req_loop;
      logic req_mul;
   } sts_type;
endpackage

@@ hdl/exact_integer_alu_core.sv @@
`timescale 1ns / 1ps
// channel | beat ports                                      | direction
// req     | req_valid/ready, req_operation, req_operand_a/b | in
// rsp     | rsp_valid/ready, rsp_value, rsp_error           | out
// One beat at a time. Simple ops: operands are registered on accept, the result is combinational from them.
// mul: the shift-add loop stops once the multiplier runs dry.
// div/quot/rem/mod: one quotient bit a cycle.
// gcd: one division per Euclid step; lcm adds a division and a multiply.
// Synchronous reset returns the controller to idle; a held rsp stalls input.
module exact_integer_alu_core #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [5:0]                   req_operation,
   input  logic signed [DATA_WIDTH-1:0] req_operand_a,
   input  logic signed [DATA_WIDTH-1:0] req_operand_b,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_value,
   output logic [1:0]                   rsp_error
);
   import eia_pkg::*;
   ctl_type ctl;
   sts_type sts;

   eia_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .sts, .ctl
   );

   eia_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock, .req_operation, .req_operand_a, .req_operand_b, .ctl, .sts,
      .rsp_value, .rsp_error
   );
endmodule

@@ hdl/eia_ctrl.sv @@
`timescale 1ns / 1ps
module eia_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  eia_pkg::sts_type  sts,
   output eia_pkg::ctl_type  ctl
);
   import eia_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      ctl.cmd   = CMD_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.cmd  = CMD_LOAD;
               state_in = ST_DONE;
               if (sts.req_div) state_in = ST_DIV;
               if (sts.req_loop) state_in = ST_GCD;
               if (sts.req_mul) state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            ctl.cmd = CMD_MUL_STEP;
            if (sts.mul_done) state_in = ST_DONE;
         end
         ST_DIV: begin
            ctl.cmd = CMD_DIV_STEP;
            if (sts.div_done) state_in = ST_DONE;
         end
         ST_GCD: begin
            if (sts.gcd_zero) begin
               if (sts.is_lcm) begin
                  ctl.cmd  = CMD_LCM_LOAD;
                  state_in = ST_LCM_DIV;
               end else begin
                  ctl.cmd  = CMD_FINISH;
                  state_in = ST_DONE;
               end
            end else begin
               ctl.cmd  = CMD_GCD_START;
               state_in = ST_DIV;
            end
         end
         ST_LCM_DIV: begin
            ctl.cmd = CMD_DIV_STEP;
            if (sts.div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      // gcd remainder loop: back to the test after each division
      if (state_ff == ST_DIV && sts.div_done && sts.is_gcd) state_in = ST_GCD;
      if (state_ff == ST_DIV && sts.div_done && sts.is_lcm) state_in = ST_GCD;
   end
endmodule

@@ hdl/eia_datapath.sv @@
`timescale 1ns / 1ps
module eia_datapath #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic [5:0]                   req_operation,
   input  logic signed [DATA_WIDTH-1:0] req_operand_a,
   input  logic signed [DATA_WIDTH-1:0] req_operand_b,
   input  eia_pkg::ctl_type             ctl,
   output eia_pkg::sts_type             sts,
   output logic signed [DATA_WIDTH-1:0] rsp_value,
   output logic [1:0]                   rsp_error
);
   import eia_pkg::*;
   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(W + 1);
   localparam int SW = $clog2(W);

   logic [5:0]   op_ff;
   logic [W-1:0] a_ff, b_ff;
   logic         lcm_pass_ff, lcm_pass_in;
   // divider: quotient/remainder restoring, one bit a cycle
   logic [W-1:0] dq_ff, dq_in, dr_ff, dr_in, dd_ff, dd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   // gcd pair
   logic [W-1:0] gx_ff, gx_in, gy_ff, gy_in;
   // shift-add multiplier
   logic [W-1:0] mp_ff, mp_in, mc_ff, mc_in, acc_ff, acc_in;
   logic [W-1:0] val_ff, val_in;
   logic [1:0]   err_ff, err_in;

   logic [W-1:0] a, b, ma, mb, trial, rsh;
   logic [W:0]   rtry;
   logic         an, bn, lt_ab, lt_ba, bpos;
   logic [W-1:0] q, r, res, shl, shr, sra_v, cnt_mag;
   logic         big;

   assign a  = req_operand_a;
   assign b  = req_operand_b;
   assign an = a[W-1];
   assign bn = b[W-1];
   assign ma = an ? -a : a;
   assign mb = bn ? -b : b;

   // registered-operand helpers
   logic ran, rbn;
   assign ran = a_ff[W-1];
   assign rbn = b_ff[W-1];
   assign q   = (ran != rbn) ? -dq_ff : dq_ff;
   assign r   = ran ? -dr_ff : dr_ff;

   assign rtry  = {dr_ff, dq_ff[W-1]} - {1'b0, dd_ff};
   assign trial = rtry[W-1:0];
   assign rsh   = {dr_ff[W-2:0], dq_ff[W-1]};

   assign lt_ab = $signed(a_ff) < $signed(b_ff);
   assign lt_ba = $signed(b_ff) < $signed(a_ff);
   assign bpos  = !rbn && (b_ff != '0);
   assign cnt_mag = bpos ? b_ff : -b_ff;
   assign big   = cnt_mag >= W'(W) || (W < 64 && cnt_mag[W-1]);
   assign shl   = big ? '0 : a_ff << cnt_mag[SW-1:0];
   assign shr   = big ? '0 : a_ff >> cnt_mag[SW-1:0];
   assign sra_v = big ? {W{ran}} : W'($signed(a_ff) >>> cnt_mag[SW-1:0]);

   always_comb begin
      // decode of the offered beat, used by the controller in idle
      sts.req_div  = (req_operation >= OP_DIV && req_operation <= OP_MOD && b != '0);
      sts.req_loop = (op_type'(req_operation) == OP_GCD) ||
                     (op_type'(req_operation) == OP_LCM);
      sts.req_mul  = (op_type'(req_operation) == OP_MUL);
      // decode of the held operation
      sts.is_div   = (op_ff >= OP_DIV && op_ff <= OP_MOD);
      sts.is_gcd   = (op_type'(op_ff) == OP_GCD);
      sts.is_lcm   = (op_type'(op_ff) == OP_LCM) && !lcm_pass_ff;
      sts.div_done = (cnt_ff == CW'(1));
      sts.gcd_zero = (gy_ff == '0);
      sts.mul_done = (mc_ff == '0);
   end

   always_comb begin
      res = '0;
      case (op_type'(op_ff))
         OP_ADD:  res = a_ff + b_ff;
         OP_SUB:  res = a_ff - b_ff;
         OP_MIN:  res = lt_ba ? b_ff : a_ff;
         OP_MAX:  res = lt_ab ? b_ff : a_ff;
         OP_ABS:  res = ran ? -a_ff : a_ff;
         OP_NEG:  res = -a_ff;
         OP_AND:  res = a_ff & b_ff;
         OP_OR:   res = a_ff | b_ff;
         OP_XOR:  res = a_ff ^ b_ff;
         OP_NOT:  res = ~a_ff;
         OP_SLL:  res = bpos ? shl : shr;
         OP_SRL:  res = bpos ? shr : shl;
         OP_SLA:  res = bpos ? shl : sra_v;
         OP_SRA:  res = bpos ? sra_v : shl;
         OP_LT:   res = W'(lt_ab);
         OP_LE:   res = W'(!lt_ba);
         OP_EQ:   res = W'(a_ff == b_ff);
         OP_GE:   res = W'(!lt_ab);
         OP_GT:   res = W'(lt_ba);
         OP_ODD:  res = W'(a_ff[0]);
         OP_EVEN: res = W'(!a_ff[0]);
         OP_ZERO: res = W'(a_ff == '0);
         OP_POS:  res = W'(!ran && a_ff != '0);
         OP_NEGP: res = W'(ran);
         OP_INC:  res = a_ff + W'(1);
         OP_DEC:  res = a_ff - W'(1);
         default: res = '0;
      endcase
   end

   always_comb begin
      dq_in = dq_ff; dr_in = dr_ff; dd_in = dd_ff; cnt_in = cnt_ff;
      gx_in = gx_ff; gy_in = gy_ff;
      mp_in = mp_ff; mc_in = mc_ff; acc_in = acc_ff;
      val_in = val_ff; err_in = err_ff; lcm_pass_in = lcm_pass_ff;
      case (ctl.cmd)
         CMD_LOAD: begin
            lcm_pass_in = 1'b0;
            dq_in = ma; dd_in = mb; dr_in = '0; cnt_in = CW'(W + 1);
            gx_in = ma; gy_in = mb;
            mp_in = a; mc_in = b; acc_in = '0;
            err_in = ERR_OK; val_in = '0;
            if (req_operation >= OP_DIV && req_operation <= OP_MOD && b == '0)
               err_in = ERR_DIV_ZERO;
         end
         CMD_DIV_STEP: begin
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff != CW'(1)) begin
               if (!rtry[W] || dr_ff[W-1]) begin
                  dr_in = trial;
                  dq_in = {dq_ff[W-2:0], 1'b1};
               end else begin
                  dr_in = rsh;
                  dq_in = {dq_ff[W-2:0], 1'b0};
               end
            end else begin
               // last count writes the result back, so W+1 counts give W bit steps
               if (sts.is_div) begin
                  case (op_type'(op_ff))
                     OP_DIV: begin
                        val_in = q;
                        if (dr_ff != '0) err_in = ERR_INEXACT;
                     end
                     OP_QUOT: val_in = q;
                     OP_REM:  val_in = r;
                     default: val_in = (r != '0 && r[W-1] != rbn) ? r + b_ff : r;
                  endcase
               end else if (lcm_pass_ff) begin
                  mp_in = ran ? -dq_ff : dq_ff;
                  mc_in = b_ff; acc_in = '0;
               end else begin
                  gx_in = gy_ff; gy_in = dr_ff;
               end
            end
         end
         CMD_GCD_START: begin
            dq_in = gx_ff; dd_in = gy_ff; dr_in = '0; cnt_in = CW'(W + 1);
         end
         CMD_FINISH: val_in = gx_ff;
         CMD_LCM_LOAD: begin
            lcm_pass_in = 1'b1;
            dq_in = ran ? -a_ff : a_ff; dd_in = gx_ff; dr_in = '0;
            cnt_in = CW'(W + 1);
            if (gx_ff == '0) begin
               dq_in = '0; dd_in = W'(1);
            end
         end
         CMD_MUL_STEP: begin
            if (mc_ff[0]) acc_in = acc_ff + mp_ff;
            mp_in = mp_ff << 1;
            mc_in = mc_ff >> 1;
            if (mc_ff == '0) begin
               if (op_type'(op_ff) == OP_LCM)
                  val_in = acc_ff[W-1] ? -acc_ff : acc_ff;
               else
                  val_in = acc_ff;
            end
         end
         default: ;
      endcase
   end

   // the restoring step keeps a leading bit in dr; track the true top bit
   always_ff @(posedge clock) begin
      if (ctl.cmd == CMD_LOAD) begin
         op_ff <= req_operation;
         a_ff  <= a;
         b_ff  <= b;
      end
      if (ctl.cmd == CMD_NONE && op_ff != OP_MUL && !(op_ff >= OP_DIV && op_ff <= OP_LCM))
         val_ff <= res;
      else
         val_ff <= val_in;
      dq_ff <= dq_in; dr_ff <= dr_in; dd_ff <= dd_in; cnt_ff <= cnt_in;
      gx_ff <= gx_in; gy_ff <= gy_in;
      mp_ff <= mp_in; mc_ff <= mc_in; acc_ff <= acc_in;
      err_ff <= err_in; lcm_pass_ff <= lcm_pass_in;
   end

   assign rsp_value = (op_ff == OP_MUL || (op_ff >= OP_DIV && op_ff <= OP_LCM))
                      ? val_ff : res;
   assign rsp_error = err_ff;
endmodule

@@ hdl/eia_checker.sv @@
`timescale 1ns / 1ps
module eia_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_error
);
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accepting while result pending");
   a_no_new_before: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("double accept");
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error != 2'd3) else $error("bad error code");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("rsp dropped");
endmodule

bind exact_integer_alu_core eia_checker u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_error
);

@@ tb/alu_result_checker.sv @@
`timescale 1ns / 1ps
module alu_result_checker #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [5:0]                   req_operation,
   input  logic signed [DATA_WIDTH-1:0] req_operand_a,
   input  logic signed [DATA_WIDTH-1:0] req_operand_b,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic signed [DATA_WIDTH-1:0] rsp_value,
   input  logic [1:0]                   rsp_error,
   output int                           mismatches,
   output int                           pending,
   output int                           results_seen
);
   import eia_pkg::*;
   localparam int W = DATA_WIDTH;
   typedef logic [W-1:0] word_type;

   typedef struct packed {
      word_type value;
      err_type  error;
   } alu_result_type;

   alu_result_type expected_q[$];

   function automatic word_type magnitude(word_type v);
      return v[W-1] ? word_type'(-v) : v;
   endfunction

   function automatic word_type euclid(word_type a, word_type b);
      word_type x, y, r;
      x = magnitude(a);
      y = magnitude(b);
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   // kind: 0 left, 1 logical right, 2 arithmetic right
   function automatic word_type shift_by(word_type a, word_type n, int kind);
      if (n >= W) return (kind == 2 && a[W-1]) ? '1 : '0;
      case (kind)
         0: return a << n;
         1: return a >> n;
         default: return word_type'($signed(a) >>> n);
      endcase
   endfunction

   function automatic word_type shift_dir(word_type a, word_type b, int fwd, int back);
      if (!b[W-1] && b != 0) return shift_by(a, b, fwd);
      return shift_by(a, word_type'(-b), back);
   endfunction

   function automatic alu_result_type compute_result(logic [5:0] op, word_type a,
                                                     word_type b);
      alu_result_type res;
      word_type ma, mb, q, r, g;
      logic signed [W-1:0] sa, sb;
      sa = a;
      sb = b;
      res.value = '0;
      res.error = ERR_OK;
      if (op inside {OP_DIV, OP_QUOT, OP_REM, OP_MOD}) begin
         if (b == 0) res.error = ERR_DIV_ZERO;
         else begin
            ma = magnitude(a);
            mb = magnitude(b);
            q = ma / mb;
            r = ma % mb;
            if (a[W-1] != b[W-1]) q = -q;
            if (a[W-1]) r = -r;
            case (op)
               OP_DIV: begin
                  res.value = q;
                  if (r != 0) res.error = ERR_INEXACT;
               end
               OP_QUOT: res.value = q;
               OP_REM:  res.value = r;
               default: begin
                  if (r != 0 && r[W-1] != b[W-1]) r = r + b;
                  res.value = r;
               end
            endcase
         end
      end else begin
         case (op)
            OP_ADD:  res.value = a + b;
            OP_SUB:  res.value = a - b;
            OP_MUL:  res.value = a * b;
            OP_GCD:  res.value = euclid(a, b);
            OP_LCM: begin
               g = euclid(a, b);
               if (g != 0) begin
                  q = magnitude(a) / g;
                  if (a[W-1]) q = -q;
                  res.value = magnitude(q * b);
               end
            end
            OP_MIN:  res.value = (sb < sa) ? b : a;
            OP_MAX:  res.value = (sa < sb) ? b : a;
            OP_ABS:  res.value = magnitude(a);
            OP_NEG:  res.value = -a;
            OP_AND:  res.value = a & b;
            OP_OR:   res.value = a | b;
            OP_XOR:  res.value = a ^ b;
            OP_NOT:  res.value = ~a;
            OP_SLL:  res.value = shift_dir(a, b, 0, 1);
            OP_SRL:  res.value = shift_dir(a, b, 1, 0);
            OP_SLA:  res.value = shift_dir(a, b, 0, 2);
            OP_SRA:  res.value = shift_dir(a, b, 2, 0);
            OP_LT:   res.value = word_type'(sa < sb);
            OP_LE:   res.value = word_type'(sa <= sb);
            OP_EQ:   res.value = word_type'(a == b);
            OP_GE:   res.value = word_type'(sa >= sb);
            OP_GT:   res.value = word_type'(sa > sb);
            OP_ODD:  res.value = word_type'(a[0]);
            OP_EVEN: res.value = word_type'(!a[0]);
            OP_ZERO: res.value = word_type'(a == 0);
            OP_POS:  res.value = word_type'(sa > 0);
            OP_NEGP: res.value = word_type'(a[W-1]);
            OP_INC:  res.value = a + 1;
            OP_DEC:  res.value = a - 1;
            default: res.value = '0;
         endcase
      end
      return res;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      alu_result_type want;
      if (reset) begin
         mismatches   <= 0;
         results_seen <= 0;
         expected_q.delete();
      end else begin
         if (req_valid && req_ready)
            expected_q.push_back(compute_result(req_operation, req_operand_a, req_operand_b));
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (expected_q.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected rsp beat: value %h error %0d", rsp_value, rsp_error);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_q.pop_front();
               if (want.value !== rsp_value || want.error !== rsp_error) begin
                  if (mismatches < 10)
                     $display("rsp mismatch: expected value %h error %0d, got value %h error %0d",
                              want.value, want.error, rsp_value, rsp_error);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
   import eia_pkg::*;
   localparam int W          = 32;
   localparam int N_RANDOM   = 600;
   localparam int STALL_LIMIT = 20000;  // idle cycles; gcd of Fibonacci-like pairs is slowest
   localparam logic [5:0] OP_UNKNOWN = 6'd63;

   typedef logic [W-1:0] word_type;
   localparam word_type MIN_W = {1'b1, {(W-1){1'b0}}};
   localparam word_type MAX_W = {1'b0, {(W-1){1'b1}}};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [5:0]        req_operation = '0;
   logic signed [W-1:0] req_operand_a = '0;
   logic signed [W-1:0] req_operand_b = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic signed [W-1:0] rsp_value;
   logic [1:0]        rsp_error;

   int  mismatches, pending, results_seen;
   int  beats_sent = 0;
   bit  calm = 1'b0;       // no idling on either side while set
   bit  hold_off = 1'b0;   // long receiver stall
   bit  stim_done = 1'b0;
   int  idle_cycles = 0;

   always #10 clock = ~clock;

   exact_integer_alu_core #(.DATA_WIDTH(W)) dut (.*);

   alu_result_checker #(.DATA_WIDTH(W)) checker_i (.*);

   // Receiver: random back-pressure, or a hard hold-off during the pressure phase.
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !hold_off && (calm || $urandom_range(99) >= 20);
   end

   // Watchdog: counts cycles with no beat on either channel.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // One beat; a sender gap is decided before valid rises, never mid-beat.
   // Valid stays up after the beat: the next gap or the caller drops it.
   task automatic send_beat(logic [5:0] op, word_type a, word_type b);
      while (!calm && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   function automatic word_type pick_operand();
      case ($urandom_range(9))
         0: return MIN_W;
         1: return MAX_W;
         2: return '0;
         3: return word_type'($urandom_range(8)) - 4;
         4, 5: return word_type'($urandom_range(200)) - 100;
         6: return word_type'($urandom_range(2 * W + 4)) - W - 2;  // shift counts near the edges
         default: return word_type'($urandom());
      endcase
   endfunction

   function automatic logic [5:0] pick_operation();
      // mostly legal codes, a few unknown ones
      if ($urandom_range(19) == 0) return 6'($urandom_range(63, 33));
      return 6'($urandom_range(OP_DEC));
   endfunction

   initial begin
      logic [5:0] op;
      word_type a, b, base;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: corner operands and every special case
      send_beat(OP_ADD, MAX_W, 1);
      send_beat(OP_SUB, MIN_W, 1);
      send_beat(OP_MUL, MIN_W, '1);
      send_beat(OP_DIV, 7, 0);              // zero divisor
      send_beat(OP_MOD, 0, 0);              // zero over zero
      send_beat(OP_DIV, 7, 2);              // inexact
      send_beat(OP_DIV, -12, 4);
      send_beat(OP_QUOT, MIN_W, '1);        // wraps to most negative
      send_beat(OP_REM, -7, 2);
      send_beat(OP_MOD, -7, 2);
      send_beat(OP_MOD, 7, -2);
      send_beat(OP_GCD, 0, -12);
      send_beat(OP_GCD, 0, 0);
      send_beat(OP_GCD, MIN_W, 0);          // magnitude 2^(W-1)
      send_beat(OP_LCM, -4, 6);
      send_beat(OP_LCM, 0, 5);
      send_beat(OP_ABS, MIN_W, 0);
      send_beat(OP_NEG, MIN_W, 0);
      send_beat(OP_SLL, 1, -1);             // negative count turns round
      send_beat(OP_SRA, MIN_W, W);          // sign fill
      send_beat(OP_SRL, '1, W + 5);
      send_beat(OP_SLA, MIN_W, -3);
      send_beat(OP_NOT, '1, '1);
      send_beat(OP_UNKNOWN, 1, 1);          // unknown code

      // Every defined code once with random operands, no idling
      calm = 1'b1;
      for (int i = 0; i <= OP_DEC; i++) send_beat(6'(i), pick_operand(), pick_operand());
      calm = 1'b0;

      // Pressure: receiver holds off while the sender keeps offering
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            for (int i = 0; i < 6; i++) send_beat(OP_ADD, $urandom(), $urandom());
            req_valid <= 1'b0;
         end
      join

      // Random part; a quiet stretch in the middle
      for (int i = 0; i < N_RANDOM; i++) begin
         calm = (i >= 250 && i < 330);
         op = pick_operation();
         a = pick_operand();
         b = pick_operand();
         // exact divides and shared factors reach the no-remainder and long gcd paths
         if ((op == OP_DIV || op == OP_GCD || op == OP_LCM) && $urandom_range(1)) begin
            base = word_type'($urandom_range(1000)) - 500;
            a = base * (word_type'($urandom_range(50)) - 25);
            b = base * (word_type'($urandom_range(50)) - 25);
            if (op == OP_DIV) a = b * (word_type'($urandom_range(40)) - 20);
         end
         send_beat(op, a, b);
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (4 * W + 20) @(posedge clock);
      $display("Covered %0d request beats and %0d result beats across all operations,",
               beats_sent, results_seen);
      $display("with directed corners, unknown codes and a long result stall.");
      if (mismatches == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
